/* rtl/core/pts_pkg.sv */
// Shared types and constants for the priority tick scheduler.
`timescale 1ns / 1ps

package pts_pkg;

    // Field widths of one transaction in each direction.
    localparam int ID_W     = 8;
    localparam int LEN_W    = 8;
    localparam int PRIO_W   = 3;
    localparam int TICK_W   = 16;
    localparam int OP_W     = 2;

    // Default sizing of the job table.
    localparam int SLOTS_DEF       = 8;
    localparam int PRIO_LEVELS_DEF = 8;

    // Operation codes carried by an input transaction.
    localparam logic [OP_W-1:0] OP_ADMIT = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Status codes of a result.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Saturated time value.
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   job_id;
        logic [LEN_W-1:0]  burst_len;
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] arrive_at;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0] run_id;
        logic            job_finished;
        logic            all_done;
        logic            status;
    } t_out;

    // One entry of the job table.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  left;
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] arrive;
    } t_slot;

endpackage

/* rtl/core/priority_tick_scheduler.sv */
// Priority tick scheduler: job table, sequential selection scan and result register.
`timescale 1ns / 1ps

// Each input transaction is admit, tick or clear, and yields exactly one result transaction.
// Admit, clear and unknown operations pass through the S_DONE state on their way to the result register.
// A tick reads the job table one entry per cycle through a single registered memory port and
// keeps the best candidate so far; in non-preemptive mode a held job that is still eligible is
// taken after a single read.
// The block accepts a new transaction only once the previous one has been handed to the result
// register, which may still be waiting to be taken. Configuration writes are always ready.
module priority_tick_scheduler #(
    parameter int SLOTS       = pts_pkg::SLOTS_DEF,
    parameter int PRIO_LEVELS = pts_pkg::PRIO_LEVELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pts_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pts_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [pts_pkg::PRIO_W-1:0] PRIO_TOP = pts_pkg::PRIO_W'(PRIO_LEVELS - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_HOLD = 6'b000010,
        S_HCHK = 6'b000100,
        S_SCAN = 6'b001000,
        S_UPD  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Job table and its registered read port.
    pts_pkg::t_slot r_mem [SLOTS];
    pts_pkg::t_slot r_rd;
    logic [IW-1:0]  rd_addr;
    logic           mem_we;
    logic [IW-1:0]  mem_wa;
    pts_pkg::t_slot mem_wd;

    // Control state.
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_live, n_live;
    logic [pts_pkg::TICK_W-1:0] r_now, n_now;
    logic [IW-1:0]              r_held, n_held;
    logic                       r_holding, n_holding;
    logic                       r_preempt;
    logic [CW-1:0]              r_idx, n_idx;
    logic                       r_dv, n_dv;
    logic [IW-1:0]              r_didx, n_didx;
    logic                       r_found, n_found;
    logic                       r_out_valid, n_out_valid;

    // Payload registers.
    logic [IW-1:0]  r_best_slot, n_best_slot;
    pts_pkg::t_slot r_best, n_best;
    pts_pkg::t_out  r_res, n_res;
    pts_pkg::t_out  r_out, n_out;

    logic                       accept;
    logic                       rd_elig;
    logic [pts_pkg::PRIO_W-1:0] in_prio;
    logic [pts_pkg::LEN_W-1:0]  best_left_dec;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign rd_addr     = r_idx[IW-1:0];

    // Eligibility of the entry on the read port, and the saturated priority of an admit.
    assign rd_elig = (r_rd.left != '0) && (r_rd.arrive <= r_now);
    assign in_prio = (32'(i_in_data.prio) > PRIO_LEVELS - 1) ? PRIO_TOP : i_in_data.prio;
    assign best_left_dec = r_best.left - pts_pkg::LEN_W'(1);

    // Next-state and datapath logic of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_live      = r_live;
        n_now       = r_now;
        n_held      = r_held;
        n_holding   = r_holding;
        n_idx       = r_idx;
        n_dv        = 1'b0;
        n_didx      = r_didx;
        n_found     = r_found;
        n_best_slot = r_best_slot;
        n_best      = r_best;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_wa      = r_count[IW-1:0];
        mem_wd      = pts_pkg::t_slot'{id: i_in_data.job_id, left: i_in_data.burst_len,
                                       prio: in_prio, arrive: i_in_data.arrive_at};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    unique case (i_in_data.op)
                        pts_pkg::OP_ADMIT: begin
                            if (r_count == SLOTS_C) begin
                                n_res.status = pts_pkg::STATUS_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                if (i_in_data.burst_len != '0) begin
                                    n_live = r_live + CW'(1);
                                end
                            end
                        end
                        pts_pkg::OP_TICK: begin
                            n_found = 1'b0;
                            if (!r_preempt && r_holding) begin
                                n_idx   = CW'(r_held);
                                n_state = S_HOLD;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        pts_pkg::OP_CLEAR: begin
                            n_count   = '0;
                            n_live    = '0;
                            n_now     = '0;
                            n_held    = '0;
                            n_holding = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HOLD: begin
                // The held entry is being read.
                n_state = S_HCHK;
            end
            S_HCHK: begin
                if (rd_elig) begin
                    n_found     = 1'b1;
                    n_best      = r_rd;
                    n_best_slot = r_held;
                    n_state     = S_UPD;
                end else begin
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue one read per cycle and compare the entry read in the cycle before.
                if (r_idx < r_count) begin
                    n_dv   = 1'b1;
                    n_didx = r_idx[IW-1:0];
                    n_idx  = r_idx + CW'(1);
                end
                if (r_dv && rd_elig && (!r_found || r_rd.prio < r_best.prio)) begin
                    n_found     = 1'b1;
                    n_best      = r_rd;
                    n_best_slot = r_didx;
                end
                if (!(r_idx < r_count) && !r_dv) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_found) begin
                    mem_we         = 1'b1;
                    mem_wa         = r_best_slot;
                    mem_wd         = r_best;
                    mem_wd.left    = best_left_dec;
                    n_res.run_id   = r_best.id;
                    n_held         = r_best_slot;
                    if (best_left_dec == '0) begin
                        n_res.job_finished = 1'b1;
                        n_holding          = 1'b0;
                        n_live             = r_live - CW'(1);
                    end else begin
                        n_holding = 1'b1;
                    end
                end else begin
                    n_holding = 1'b0;
                end
                if (r_now != pts_pkg::TICK_MAX) begin
                    n_now = r_now + pts_pkg::TICK_W'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out          = r_res;
                    n_out.all_done = (r_live == '0);
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_live      <= '0;
            r_now       <= '0;
            r_held      <= '0;
            r_holding   <= 1'b0;
            r_preempt   <= 1'b0;
            r_idx       <= '0;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_live      <= n_live;
            r_now       <= n_now;
            r_held      <= n_held;
            r_holding   <= n_holding;
            r_idx       <= n_idx;
            r_dv        <= n_dv;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_preempt <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_didx      <= n_didx;
        r_best_slot <= n_best_slot;
        r_best      <= n_best;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    // Job table memory with one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[rd_addr];
    end

endmodule

/* rtl/core/pts_checker.sv */
// Port-level checker for the priority tick scheduler, bound to the top level.
`timescale 1ns / 1ps

module pts_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input pts_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input pts_pkg::t_out o_out_data
);

    // A result waiting on a stall holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result transaction changed or vanished");

    // No result appears straight out of reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result transaction present after reset");

    // An accepted transaction keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted again directly after a transaction");

    // Completion comes only from a tick and a full-table status only from an admit, so no result reports both.
    a_fin_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.job_finished &&
                          o_out_data.status == pts_pkg::STATUS_FULL))
        else $error("result reports both completion and a rejected admit");

    // A rejected admit runs no job.
    a_full_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == pts_pkg::STATUS_FULL |->
            o_out_data.run_id == '0)
        else $error("rejected admit reports a running job");

endmodule

bind priority_tick_scheduler pts_checker u_pts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
